### rtl/tmcm_pkg.sv
// shared types, constants and helpers for the tiled mirror coordinate map
// no dependencies
package tmcm_pkg;

    localparam int MAX_TILES = 6;
    localparam int COORD_W   = 16;
    localparam int TILE_W    = $clog2(MAX_TILES + 1);
    localparam int MASK_W    = MAX_TILES * MAX_TILES;
    localparam int IDX_W     = $clog2(MASK_W);
    localparam int PROD_W    = COORD_W + TILE_W;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_TILE_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP_H_MASK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP_V_MASK  = 3'd4;

    // per-axis result: tile index, remainder and effective frame size
    typedef struct packed {
        logic [TILE_W-1:0]  tile;
        logic [COORD_W-1:0] rem;
        logic [COORD_W-1:0] size;
    } t_axis_res;

    function automatic logic [TILE_W-1:0] eff_tiles(input logic [2:0] n);
        logic [TILE_W-1:0] r;
        r = TILE_W'(n);
        if (n < 3'd2) r = TILE_W'(2);
        if (n > 3'(MAX_TILES)) r = TILE_W'(MAX_TILES);
        return r;
    endfunction

endpackage

### rtl/tmcm_axis.sv
// one axis of the coordinate map: clamp, scale by tile count, split into tile and remainder
// depends on tmcm_pkg
module tmcm_axis (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [tmcm_pkg::COORD_W-1:0]  i_d,
    input  logic [tmcm_pkg::COORD_W-1:0]  i_s,
    input  logic [2:0]                    i_n,
    output tmcm_pkg::t_axis_res           o_res
);
    import tmcm_pkg::*;

    logic [COORD_W-1:0] r_d1, r_s1, n_d1, n_s1;
    logic [TILE_W-1:0]  r_n1;
    logic [PROD_W-1:0]  r_p2, r_m3, r_m5;
    logic [COORD_W-1:0] r_s2;
    t_axis_res          r_res, n_res;
    logic [PROD_W-1:0]  m1, m2, m4, sub;

    always_comb begin
        n_s1 = (i_s == '0) ? COORD_W'(1) : i_s;
        n_d1 = (i_d >= n_s1) ? n_s1 - COORD_W'(1) : i_d;
    end

    assign m1 = PROD_W'(r_s2);
    assign m2 = PROD_W'(r_s2) << 1;
    assign m4 = PROD_W'(r_s2) << 2;

    // quotient is below the tile count, so a few compares find it
    always_comb begin
        n_res.size = r_s2;
        n_res.tile = '0;
        sub        = '0;
        if (r_p2 >= m1) begin n_res.tile = TILE_W'(1); sub = m1;   end
        if (r_p2 >= m2) begin n_res.tile = TILE_W'(2); sub = m2;   end
        if (r_p2 >= r_m3) begin n_res.tile = TILE_W'(3); sub = r_m3; end
        if (r_p2 >= m4) begin n_res.tile = TILE_W'(4); sub = m4;   end
        if (r_p2 >= r_m5) begin n_res.tile = TILE_W'(5); sub = r_m5; end
        n_res.rem = COORD_W'(r_p2 - sub);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d1  <= n_d1;
            r_s1  <= n_s1;
            r_n1  <= eff_tiles(i_n);
            r_p2  <= PROD_W'(r_d1) * PROD_W'(r_n1);
            r_m3  <= PROD_W'(r_s1) + (PROD_W'(r_s1) << 1);
            r_m5  <= PROD_W'(r_s1) + (PROD_W'(r_s1) << 2);
            r_s2  <= r_s1;
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

### rtl/tiled_mirror_coordinate_map.sv
// Tiled mirror coordinate map: for each destination pixel it returns the source pixel that
// shows an n-by-n grid of shrunken, individually mirrored copies of the frame, plus the
// tile's mirror flags. Fully pipelined: one transaction per clock while not stalled, through
// four register stages (clamp, multiply, tile/remainder split, mirror and output register).
// A stall on a valid output freezes the whole pipe and is reflected on o_stall in the same
// cycle.
// Configuration writes are always taken and must only occur while the pipe is empty.
// depends on tmcm_pkg and tmcm_axis
module tiled_mirror_coordinate_map (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tmcm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tmcm_pkg::MASK_W-1:0]     i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [tmcm_pkg::COORD_W-1:0]    i_dest_x,
    input  logic [tmcm_pkg::COORD_W-1:0]    i_dest_y,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [tmcm_pkg::COORD_W-1:0]    o_src_x,
    output logic [tmcm_pkg::COORD_W-1:0]    o_src_y,
    output logic                            o_mirrored_h,
    output logic                            o_mirrored_v
);
    import tmcm_pkg::*;

    // configuration registers
    logic [2:0]         r_tiles;
    logic [COORD_W-1:0] r_width, r_height;
    logic [MASK_W-1:0]  r_mask_h, r_mask_v;

    // pipeline control
    logic       en;
    logic [2:0] r_vld;
    logic       r_out_vld;

    t_axis_res  res_x, res_y;
    logic [IDX_W-1:0] idx;
    logic       fh, fv;
    logic [COORD_W-1:0] r_src_x, r_src_y, n_src_x, n_src_y;
    logic       r_fh, r_fv;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tiles  <= 3'd2;
            r_width  <= COORD_W'(1);
            r_height <= COORD_W'(1);
            r_mask_h <= '0;
            r_mask_v <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TILE_COUNT:   r_tiles  <= i_cfg_data[2:0];
                CFG_FRAME_WIDTH:  r_width  <= i_cfg_data[COORD_W-1:0];
                CFG_FRAME_HEIGHT: r_height <= i_cfg_data[COORD_W-1:0];
                CFG_FLIP_H_MASK:  r_mask_h <= i_cfg_data;
                CFG_FLIP_V_MASK:  r_mask_v <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // the whole pipe advances unless a finished result is held by the receiver
    assign en      = !(r_out_vld && i_stall);
    assign o_stall = !en;

    tmcm_axis u_axis_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (i_dest_x),
        .i_s   (r_width),
        .i_n   (r_tiles),
        .o_res (res_x)
    );

    tmcm_axis u_axis_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (i_dest_y),
        .i_s   (r_height),
        .i_n   (r_tiles),
        .o_res (res_y)
    );

    // mask bit per tile at column*MAX_TILES + row
    assign idx = IDX_W'(res_x.tile) * IDX_W'(MAX_TILES) + IDX_W'(res_y.tile);
    assign fh  = r_mask_h[idx];
    assign fv  = r_mask_v[idx];

    // a mirrored axis lands at size-1-remainder
    assign n_src_x = fh ? res_x.size - COORD_W'(1) - res_x.rem : res_x.rem;
    assign n_src_y = fv ? res_y.size - COORD_W'(1) - res_y.rem : res_y.rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[1:0], i_valid};
            r_out_vld <= r_vld[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_src_x <= n_src_x;
            r_src_y <= n_src_y;
            r_fh    <= fh;
            r_fv    <= fv;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_src_x      = r_src_x;
    assign o_src_y      = r_src_y;
    assign o_mirrored_h = r_fh;
    assign o_mirrored_v = r_fv;

`ifndef SYNTH
    // a held result is never dropped
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && i_stall |=> r_out_vld)
        else $error("result lost under stall");

    // in-flight items do not move while stalled
    a_pipe_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipe advanced while stalled");

    // nothing comes out right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");
`endif

endmodule
